>>> hdl/ordered_array_list_assert.svh
// assertion macros for the ordered array list
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/oal_pkg.sv
// types and codes shared by the ordered array list
package oal_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_WRITE  = 2'd3;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] item_out;
    logic [6:0]         length_now;
  } out_item_t;

endpackage

>>> hdl/ordered_array_list.sv
// ordered array list: insert, delete, read and write by index over one memory
// write and errors answer from idle; read passes RDOUT; insert moves each entry from
// position up via RD and WR, then FIN; delete passes RDOUT, moves later entries down, FIN
// throughput: one item at a time, next item accepted once busy is low
// the result strobe lasts one cycle and the receiver cannot stall it
// reset: synchronous active-low, clears the count and control; entries are left as they are
`include "ordered_array_list_assert.svh"

module ordered_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  oal_pkg::in_item_t   in_item,
  output logic                out_valid,
  output oal_pkg::out_item_t  out_item
);

  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > 6) ? LW : 6) + 1;
  localparam int OW = (LW > 7) ? LW : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rdata_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [AW-1:0]      rd_addr;

  logic [2:0]         state_r, state_nxt;
  logic [LW-1:0]      length_r, length_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [31:0]        val_r, val_nxt;
  logic               out_valid_r, out_valid_nxt;
  oal_pkg::out_item_t out_item_r, out_item_nxt;

  logic               accept;
  logic [CW-1:0]      len_c;
  logic [CW-1:0]      pos_c;
  logic [CW-1:0]      idx_c;
  logic               full;
  logic [LW-1:0]      len_inc, len_dec;
  logic [OW-1:0]      len_o, inc_o, dec_o;

  assign accept  = start && (state_r == S_IDLE);
  assign len_c   = CW'(length_r);
  assign pos_c   = CW'(in_item.position);
  assign idx_c   = CW'(idx_r);
  assign full    = (length_r == LW'(CAPACITY));
  assign len_inc = length_r + LW'(1);
  assign len_dec = length_r - LW'(1);
  assign len_o   = OW'(length_r);
  assign inc_o   = OW'(len_inc);
  assign dec_o   = OW'(len_dec);

  always_comb begin
    state_nxt     = state_r;
    length_nxt    = length_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rdata_r;
    rd_addr       = idx_r;
    case (state_r)
      S_IDLE: begin
        rd_addr = pos_c[AW-1:0];
        if (accept) begin
          op_nxt  = in_item.req_type;
          pos_nxt = pos_c[AW-1:0];
          val_nxt = in_item.item_value;
          idx_nxt = pos_c[AW-1:0];
          out_item_nxt.status     = oal_pkg::STATUS_ERROR;
          out_item_nxt.item_out   = '0;
          out_item_nxt.length_now = len_o[6:0];
          case (in_item.req_type)
            oal_pkg::OP_INSERT: begin
              if (full || (pos_c > len_c)) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = length_r[AW-1:0];
                state_nxt = (pos_c == len_c) ? S_FIN : S_RD;
              end
            end
            oal_pkg::OP_WRITE: begin
              out_valid_nxt = 1'b1;
              if (pos_c < len_c) begin
                wr_en   = 1'b1;
                wr_addr = pos_c[AW-1:0];
                wr_data = in_item.item_value;
                out_item_nxt.status   = oal_pkg::STATUS_DONE;
                out_item_nxt.item_out = in_item.item_value;
              end
            end
            default: begin
              if (pos_c < len_c) begin
                state_nxt = S_RDOUT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_RDOUT: begin
        if (op_r == oal_pkg::OP_READ) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.status     = oal_pkg::STATUS_DONE;
          out_item_nxt.item_out   = rdata_r;
          out_item_nxt.length_now = len_o[6:0];
          state_nxt = S_IDLE;
        end else begin
          val_nxt   = rdata_r;
          state_nxt = ((idx_c + CW'(1)) < len_c) ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        rd_addr   = (op_r == oal_pkg::OP_INSERT) ? (idx_r - AW'(1)) : (idx_r + AW'(1));
        state_nxt = S_WR;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rdata_r;
        if (op_r == oal_pkg::OP_INSERT) begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = ((idx_r - AW'(1)) == pos_r) ? S_FIN : S_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ((idx_c + CW'(2)) < len_c) ? S_RD : S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_item_nxt.status   = oal_pkg::STATUS_DONE;
        out_item_nxt.item_out = val_r;
        state_nxt = S_IDLE;
        if (op_r == oal_pkg::OP_INSERT) begin
          wr_en      = 1'b1;
          wr_addr    = pos_r;
          wr_data    = val_r;
          length_nxt = len_inc;
          out_item_nxt.length_now = inc_o[6:0];
        end else begin
          length_nxt = len_dec;
          out_item_nxt.length_now = dec_o[6:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `OAL_ASSERT_NOW(a_len_bound, 1'b1, length_r <= LW'(CAPACITY), "count above capacity")
  `OAL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "item accepted but dropped")
  `OAL_ASSERT_NOW(a_done_emits, $fell(busy), out_valid, "sequence ended without a result")

endmodule
